@@ src/nsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence field extractor package
// Shared types and character constants for the PHTG sentence parser.
// ----------------------------------------------------------------------------
package nsfe_pkg;

   // ASCII characters that steer the parser.
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FFEED   = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Sentence prefix after the dollar sign: "PHTG".
   localparam logic [7:0] HEAD_P = 8'h50;
   localparam logic [7:0] HEAD_H = 8'h48;
   localparam logic [7:0] HEAD_T = 8'h54;
   localparam logic [7:0] HEAD_G = 8'h47;

   // Character position where the body starts; the counter saturates here.
   localparam logic [2:0] BODY_POS = 3'd6;
   // Comma count of the two numeric fields and its saturation value.
   localparam logic [2:0] FIELD_AUTH = 3'd4;
   localparam logic [2:0] FIELD_WARN = 3'd5;
   localparam logic [2:0] FIELD_MAX  = 3'd6;

   // Classified input byte, produced by the front end.
   typedef struct packed {
      logic       dollar;
      logic       newline;
      logic       star;
      logic       comma;
      logic       digit;
      logic       blank;
      logic       plus;
      logic       minus;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic [3:0] digit_val;
      logic [7:0] data;
   } nsfe_class_type;

   // One result per ended sentence.
   typedef struct packed {
      logic               accepted;
      logic signed [31:0] auth_status;
      logic signed [31:0] warning_level;
   } nsfe_result_type;

   // Expected character at prefix positions one to four.
   function automatic logic [7:0] head_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd1:    ch = HEAD_P;
         3'd2:    ch = HEAD_H;
         3'd3:    ch = HEAD_T;
         3'd4:    ch = HEAD_G;
         default: ch = CHAR_DOLLAR;
      endcase
      return ch;
   endfunction

endpackage

@@ src/nmea_sentence_field_extractor.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence field extractor
// Parses PHTG sentences from a byte stream: prefix, XOR checksum, and the
// signed decimal fields four and five, with one result per ended sentence.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained while results are taken.
// A closing newline passes through the classify queue and then the back end
//    before its result reaches the result queue and the result ports.
// The back end retires one queued byte per cycle; it pauses when the result
//    queue is full or no byte is queued.
// Reset: synchronous, clears both queues, the sentence state and the stored
//    field values to zero; no sweep is needed after reset.
module nmea_sentence_field_extractor
   import nsfe_pkg::*;
#(
   parameter int REQ_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_data_byte,
   output logic               req_full,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic               rsp_accepted,
   output logic signed [31:0] rsp_auth_status,
   output logic signed [31:0] rsp_warning_level
);

   nsfe_class_type  item;
   logic            item_empty;
   logic            item_pop;
   logic            rsp_full;
   logic            rsp_push;
   nsfe_result_type rsp_data;
   nsfe_result_type rsp_head;

   // Front end: byte intake and classification.
   nsfe_front #(
      .DEPTH (REQ_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .item_pop      (item_pop),
      .item          (item),
      .item_empty    (item_empty)
   );

   // Back end: sentence state and verdict.
   nsfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data)
   );

   // Result queue toward the consumer.
   nsfe_queue #(
      .WIDTH ($bits(nsfe_result_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_accepted      = rsp_head.accepted;
   assign rsp_auth_status   = rsp_head.auth_status;
   assign rsp_warning_level = rsp_head.warning_level;

endmodule

@@ src/nsfe_queue.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence field extractor queue
// Small register queue with push/full and pop/empty; DEPTH must be a power of two (not checked by the queue).
// ----------------------------------------------------------------------------
module nsfe_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update for each transfer.
   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/nsfe_front.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence field extractor front end
// Takes serial bytes, classifies each one and queues it for the back end.
// ----------------------------------------------------------------------------
module nsfe_front
   import nsfe_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   input  logic [7:0]     req_data_byte,
   output logic           req_full,
   input  logic           item_pop,
   output nsfe_class_type item,
   output logic           item_empty
);

   nsfe_class_type cls;
   logic [7:0]     b;
   logic           is_upper_hex;
   logic           is_lower_hex;

   assign b = req_data_byte;

   // Character classes used by the sentence logic.
   always_comb begin
      is_upper_hex  = (b >= 8'h41) && (b <= 8'h46);
      is_lower_hex  = (b >= 8'h61) && (b <= 8'h66);
      cls.dollar    = (b == CHAR_DOLLAR);
      cls.newline   = (b == CHAR_NEWLINE);
      cls.star      = (b == CHAR_STAR);
      cls.comma     = (b == CHAR_COMMA);
      cls.digit     = (b >= 8'h30) && (b <= 8'h39);
      cls.blank     = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VTAB) ||
                      (b == CHAR_FFEED) || (b == CHAR_CR);
      cls.plus      = (b == CHAR_PLUS);
      cls.minus     = (b == CHAR_MINUS);
      cls.hex_ok    = cls.digit || is_upper_hex || is_lower_hex;
      cls.digit_val = b[3:0];
      // Letters A-F and a-f have low nibble 1..6; add nine for 10..15.
      cls.hex_val   = cls.digit ? b[3:0] : 4'(b[3:0] + 4'd9);
      cls.data      = b;
   end

   // The queue decouples the byte stream from the sentence logic.
   nsfe_queue #(
      .WIDTH ($bits(nsfe_class_type)),
      .DEPTH (DEPTH)
   ) u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (item),
      .empty     (item_empty)
   );

endmodule

@@ src/nsfe_back.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence field extractor back end
// Runs the sentence state for each classified byte and issues results.
// ----------------------------------------------------------------------------
module nsfe_back
   import nsfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  nsfe_class_type  item,
   input  logic            item_empty,
   output logic            item_pop,
   input  logic            rsp_full,
   output logic            rsp_push,
   output nsfe_result_type rsp_data
);

   localparam logic signed [36:0] ACC_MAX = 37'sd2147483647;
   localparam logic signed [36:0] ACC_MIN = -37'sd2147483648;

   logic               in_sentence_ff, in_sentence_in;
   logic [2:0]         char_pos_ff, char_pos_in;
   logic               prefix_ok_ff, prefix_ok_in;
   logic [7:0]         xor_ff, xor_in;
   logic               star_ff, star_in;
   logic [1:0]         hex_cnt_ff, hex_cnt_in;
   logic [7:0]         sum_ff, sum_in;
   logic               hex_bad_ff, hex_bad_in;
   logic [2:0]         field_idx_ff, field_idx_in;
   logic signed [31:0] pend_auth_ff, pend_auth_in;
   logic signed [31:0] pend_warn_ff, pend_warn_in;
   logic               sign_ff, sign_in;
   logic               neg_ff, neg_in;
   logic               digit_ff, digit_in;
   logic               ovf_ff, ovf_in;
   logic               stop_ff, stop_in;
   logic               f4ok_ff, f4ok_in;
   logic               f5ok_ff, f5ok_in;
   logic signed [31:0] stored_auth_ff, stored_auth_in;
   logic signed [31:0] stored_warn_ff, stored_warn_in;

   logic               fire;
   logic               field_good;
   logic               sum_ok;
   logic               f5_good;
   logic               sentence_ok;
   logic               num_field;
   logic               fresh;
   logic signed [31:0] acc_sel;
   logic signed [36:0] acc_wide;
   logic signed [36:0] acc_x10;
   logic signed [36:0] digit_wide;
   logic signed [36:0] acc_next;
   logic               acc_ovf;

   // One byte is retired per cycle while the result queue has room.
   assign fire     = !item_empty && !rsp_full;
   assign item_pop = fire;

   // Sentence verdict from the state before the newline.
   always_comb begin
      field_good  = digit_ff && !ovf_ff;
      sum_ok      = star_ff && (hex_cnt_ff == 2'd2) && !hex_bad_ff && (sum_ff == xor_ff);
      f5_good     = (field_idx_ff == FIELD_WARN) ? field_good : f5ok_ff;
      sentence_ok = prefix_ok_ff && (char_pos_ff >= 3'd5) && sum_ok &&
                    (field_idx_ff >= FIELD_WARN) && f4ok_ff && f5_good;
   end

   // Decimal accumulation: times ten by shifts, then add or subtract the digit.
   always_comb begin
      num_field  = (field_idx_ff == FIELD_AUTH) || (field_idx_ff == FIELD_WARN);
      fresh      = !sign_ff && !digit_ff;
      acc_sel    = (field_idx_ff == FIELD_AUTH) ? pend_auth_ff : pend_warn_ff;
      acc_wide   = 37'(acc_sel);
      acc_x10    = (acc_wide <<< 3) + (acc_wide <<< 1);
      digit_wide = signed'({33'd0, item.digit_val});
      acc_next   = neg_ff ? (acc_x10 - digit_wide) : (acc_x10 + digit_wide);
      acc_ovf    = neg_ff ? (acc_next < ACC_MIN) : (acc_next > ACC_MAX);
   end

   // Next state for the byte being retired.
   always_comb begin
      in_sentence_in = in_sentence_ff;
      char_pos_in    = char_pos_ff;
      prefix_ok_in   = prefix_ok_ff;
      xor_in         = xor_ff;
      star_in        = star_ff;
      hex_cnt_in     = hex_cnt_ff;
      sum_in         = sum_ff;
      hex_bad_in     = hex_bad_ff;
      field_idx_in   = field_idx_ff;
      pend_auth_in   = pend_auth_ff;
      pend_warn_in   = pend_warn_ff;
      sign_in        = sign_ff;
      neg_in         = neg_ff;
      digit_in       = digit_ff;
      ovf_in         = ovf_ff;
      stop_in        = stop_ff;
      f4ok_in        = f4ok_ff;
      f5ok_in        = f5ok_ff;
      stored_auth_in = stored_auth_ff;
      stored_warn_in = stored_warn_ff;
      rsp_push       = 1'b0;

      rsp_data.accepted      = sentence_ok;
      rsp_data.auth_status   = sentence_ok ? pend_auth_ff : stored_auth_ff;
      rsp_data.warning_level = sentence_ok ? pend_warn_ff : stored_warn_ff;

      if (fire && !item.dollar) begin
         if (item.newline) begin
            // End of sentence: report and keep the values of a good one.
            if (in_sentence_ff) begin
               rsp_push       = 1'b1;
               in_sentence_in = 1'b0;
               if (sentence_ok) begin
                  stored_auth_in = pend_auth_ff;
                  stored_warn_in = pend_warn_ff;
               end
            end
         end else if (in_sentence_ff) begin
            // Prefix check at positions one to four.
            if ((char_pos_ff >= 3'd1) && (char_pos_ff <= 3'd4) &&
                (item.data != head_char(char_pos_ff))) begin
               prefix_ok_in = 1'b0;
            end

            priority if (star_ff) begin
               // Two checksum digits after the asterisk.
               if (hex_cnt_ff < 2'd2) begin
                  if (!item.hex_ok) begin
                     hex_bad_in = 1'b1;
                  end else begin
                     sum_in = {sum_ff[3:0], item.hex_val};
                  end
                  hex_cnt_in = 2'(hex_cnt_ff + 1'b1);
               end
            end else if (item.star) begin
               star_in = 1'b1;
               if (char_pos_ff <= 3'd5) begin
                  prefix_ok_in = 1'b0;
               end
            end else begin
               xor_in = xor_ff ^ item.data;
               if (char_pos_ff >= BODY_POS) begin
                  if (item.comma) begin
                     // Field boundary: latch the verdict of a numeric field.
                     if ((field_idx_ff == FIELD_AUTH) && field_good) begin
                        f4ok_in = 1'b1;
                     end
                     if ((field_idx_ff == FIELD_WARN) && field_good) begin
                        f5ok_in = 1'b1;
                     end
                     sign_in  = 1'b0;
                     neg_in   = 1'b0;
                     digit_in = 1'b0;
                     ovf_in   = 1'b0;
                     stop_in  = 1'b0;
                     if (field_idx_ff < FIELD_MAX) begin
                        field_idx_in = 3'(field_idx_ff + 1'b1);
                     end
                  end else if (num_field && !stop_ff) begin
                     priority if (fresh && item.blank) begin
                        // Leading blanks are skipped.
                     end else if (fresh && (item.plus || item.minus)) begin
                        sign_in = 1'b1;
                        neg_in  = neg_ff || item.minus;
                     end else if (item.digit) begin
                        digit_in = 1'b1;
                        if (!ovf_ff) begin
                           if (acc_ovf) begin
                              ovf_in = 1'b1;
                           end else if (field_idx_ff == FIELD_AUTH) begin
                              pend_auth_in = 32'(acc_next);
                           end else begin
                              pend_warn_in = 32'(acc_next);
                           end
                        end
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
            end

            if (char_pos_ff < BODY_POS) begin
               char_pos_in = 3'(char_pos_ff + 1'b1);
            end
         end
      end

      // A dollar sign or an ended sentence clears the per-sentence state.
      if (fire && (item.dollar || (item.newline && in_sentence_ff))) begin
         char_pos_in  = 3'd0;
         prefix_ok_in = 1'b1;
         xor_in       = 8'd0;
         star_in      = 1'b0;
         hex_cnt_in   = 2'd0;
         sum_in       = 8'd0;
         hex_bad_in   = 1'b0;
         field_idx_in = 3'd0;
         pend_auth_in = 32'sd0;
         pend_warn_in = 32'sd0;
         sign_in      = 1'b0;
         neg_in       = 1'b0;
         digit_in     = 1'b0;
         ovf_in       = 1'b0;
         stop_in      = 1'b0;
         f4ok_in      = 1'b0;
         f5ok_in      = 1'b0;
         if (item.dollar) begin
            in_sentence_in = 1'b1;
            char_pos_in    = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         char_pos_ff    <= 3'd0;
         prefix_ok_ff   <= 1'b1;
         xor_ff         <= 8'd0;
         star_ff        <= 1'b0;
         hex_cnt_ff     <= 2'd0;
         sum_ff         <= 8'd0;
         hex_bad_ff     <= 1'b0;
         field_idx_ff   <= 3'd0;
         pend_auth_ff   <= 32'sd0;
         pend_warn_ff   <= 32'sd0;
         sign_ff        <= 1'b0;
         neg_ff         <= 1'b0;
         digit_ff       <= 1'b0;
         ovf_ff         <= 1'b0;
         stop_ff        <= 1'b0;
         f4ok_ff        <= 1'b0;
         f5ok_ff        <= 1'b0;
         stored_auth_ff <= 32'sd0;
         stored_warn_ff <= 32'sd0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         char_pos_ff    <= char_pos_in;
         prefix_ok_ff   <= prefix_ok_in;
         xor_ff         <= xor_in;
         star_ff        <= star_in;
         hex_cnt_ff     <= hex_cnt_in;
         sum_ff         <= sum_in;
         hex_bad_ff     <= hex_bad_in;
         field_idx_ff   <= field_idx_in;
         pend_auth_ff   <= pend_auth_in;
         pend_warn_ff   <= pend_warn_in;
         sign_ff        <= sign_in;
         neg_ff         <= neg_in;
         digit_ff       <= digit_in;
         ovf_ff         <= ovf_in;
         stop_ff        <= stop_in;
         f4ok_ff        <= f4ok_in;
         f5ok_ff        <= f5ok_in;
         stored_auth_ff <= stored_auth_in;
         stored_warn_ff <= stored_warn_in;
      end
   end

   // A result is only issued for a newline that closes an open sentence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (fire && item.newline && in_sentence_ff))
      else $error("result issued without an ending newline");

   // A retired dollar sign opens a sentence at position one.
   assert property (@(posedge clock) disable iff (reset)
      (fire && item.dollar) |=> (in_sentence_ff && (char_pos_ff == 3'd1) && !star_ff))
      else $error("dollar sign did not restart the sentence");

   // Outside a sentence the per-sentence state stays cleared.
   assert property (@(posedge clock) disable iff (reset)
      !in_sentence_ff |-> ((xor_ff == 8'd0) && !star_ff && (field_idx_ff == 3'd0)))
      else $error("sentence state not cleared outside a sentence");

   // Counters never pass their saturation values.
   assert property (@(posedge clock) disable iff (reset)
      (char_pos_ff <= BODY_POS) && (field_idx_ff <= FIELD_MAX) && (hex_cnt_ff <= 2'd2))
      else $error("sentence counter out of range");

endmodule
